// ----- rtl/mcle_pkg.sv -----
// Shared types and character codes for the multi-console line editor.
package mcle_pkg;

    // Control characters that the line discipline recognizes.
    localparam logic [7:0] K_CTRL_D = 8'h04;
    localparam logic [7:0] K_CTRL_H = 8'h08;
    localparam logic [7:0] K_LF     = 8'h0A;
    localparam logic [7:0] K_CR     = 8'h0D;
    localparam logic [7:0] K_CTRL_P = 8'h10;
    localparam logic [7:0] K_CTRL_Q = 8'h11;
    localparam logic [7:0] K_CTRL_S = 8'h13;
    localparam logic [7:0] K_CTRL_U = 8'h15;
    localparam logic [7:0] K_DEL    = 8'h7F;

    // Echo kinds.
    localparam logic [1:0] ECHO_NONE  = 2'd0;
    localparam logic [1:0] ECHO_BYTE  = 2'd1;
    localparam logic [1:0] ECHO_ERASE = 2'd2;

    // Dump requests.
    localparam logic [1:0] DUMP_NONE = 2'd0;
    localparam logic [1:0] DUMP_PROC = 2'd1;
    localparam logic [1:0] DUMP_PRIO = 2'd2;

    // Read status codes.
    localparam logic [2:0] RS_BYTE     = 3'd0;
    localparam logic [2:0] RS_NEWLINE  = 3'd1;
    localparam logic [2:0] RS_EOF      = 3'd2;
    localparam logic [2:0] RS_EOF_HELD = 3'd3;
    localparam logic [2:0] RS_EMPTY    = 3'd4;
    localparam logic [2:0] RS_INACTIVE = 3'd5;

    // Item action codes.
    localparam logic ACT_KEY  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // One input item.
    typedef struct packed {
        logic       action;
        logic [7:0] key;
        logic [1:0] console_index;
        logic       first_of_read;
    } t_in;

    // One result item.
    typedef struct packed {
        logic [1:0] echo_kind;
        logic [7:0] echo_byte;
        logic [7:0] erase_count;
        logic       line_committed;
        logic [1:0] active_now;
        logic       switched;
        logic [1:0] dump_request;
        logic [2:0] read_status;
        logic [7:0] read_byte;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic exec;
        logic kill_start;
        logic kill_rd;
        logic kill_step;
        logic kill_done;
        logic rd_issue;
        logic rd_done;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_kill;
        logic read_go;
        logic kill_more;
        logic hit_lf;
        logic out_free;
    } t_status;

endpackage

// ----- rtl/mcle_ctrl.sv -----
// Controller state machine for the multi-console line editor.
module mcle_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  mcle_pkg::t_status i_sts,
    output logic              o_in_ready,
    output mcle_pkg::t_cmd    o_cmd
);
    import mcle_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_DISPATCH  = 6'b000010,
        S_KILL_TEST = 6'b000100,
        S_KILL_CHK  = 6'b001000,
        S_KILL_FIN  = 6'b010000,
        S_RD_WAIT   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_sts.read_go) begin
                    o_cmd.rd_issue = 1'b1;
                    n_state        = S_RD_WAIT;
                end else if (i_sts.is_kill) begin
                    o_cmd.kill_start = 1'b1;
                    n_state          = S_KILL_TEST;
                end else if (i_sts.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_KILL_TEST: begin
                // Fetch the byte before the edit position, if any is uncommitted.
                if (i_sts.kill_more) begin
                    o_cmd.kill_rd = 1'b1;
                    n_state       = S_KILL_CHK;
                end else begin
                    n_state = S_KILL_FIN;
                end
            end
            S_KILL_CHK: begin
                if (i_sts.hit_lf) begin
                    n_state = S_KILL_FIN;
                end else begin
                    o_cmd.kill_step = 1'b1;
                    n_state         = S_KILL_TEST;
                end
            end
            S_KILL_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.kill_done = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_RD_WAIT: begin
                if (i_sts.out_free) begin
                    o_cmd.rd_done = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ----- rtl/mcle_dp.sv -----
// Datapath for the multi-console line editor: indices, line store and result register.
module mcle_dp #(
    parameter int BUFFER_DEPTH  = 128,
    parameter int CONSOLE_COUNT = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mcle_pkg::t_cmd    i_cmd,
    input  mcle_pkg::t_in     i_in_data,
    input  logic              i_out_ready,
    output mcle_pkg::t_status o_sts,
    output logic              o_out_valid,
    output mcle_pkg::t_out    o_out_data
);
    import mcle_pkg::*;

    localparam int SW    = $clog2(BUFFER_DEPTH);
    localparam int PW    = SW + 1;
    localparam int CW    = (CONSOLE_COUNT > 1) ? $clog2(CONSOLE_COUNT) : 1;
    localparam int MEM_N = CONSOLE_COUNT * BUFFER_DEPTH;
    localparam int AW    = $clog2(MEM_N);
    localparam int NW    = $clog2(BUFFER_DEPTH + 1);

    // Position step forward with wrap bit toggling at the ring end.
    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        logic [PW-1:0] q;
        if (p[SW-1:0] == SW'(BUFFER_DEPTH - 1)) begin
            q = {~p[SW], {SW{1'b0}}};
        end else begin
            q = {p[SW], p[SW-1:0] + SW'(1)};
        end
        return q;
    endfunction

    // Position step backward.
    function automatic logic [PW-1:0] f_dec(input logic [PW-1:0] p);
        logic [PW-1:0] q;
        if (p[SW-1:0] == '0) begin
            q = {~p[SW], SW'(BUFFER_DEPTH - 1)};
        end else begin
            q = {p[SW], p[SW-1:0] - SW'(1)};
        end
        return q;
    endfunction

    t_in           r_item;
    logic [CW-1:0] r_active;
    logic [PW-1:0] r_rd_pos [CONSOLE_COUNT];
    logic [PW-1:0] r_cm_pos [CONSOLE_COUNT];
    logic [PW-1:0] r_ed_pos [CONSOLE_COUNT];
    logic [NW-1:0] r_cnt;
    logic [7:0]    r_mem_q;
    logic [7:0]    r_mem [MEM_N];
    t_out          r_out;
    logic          r_out_vld;

    logic [CW-1:0] n_active;
    logic [PW-1:0] n_rd;
    logic [PW-1:0] n_cm;
    logic [PW-1:0] n_ed;
    t_out          n_out;
    logic          w_out_load;

    logic [PW-1:0] cur_rd;
    logic [PW-1:0] cur_cm;
    logic [PW-1:0] cur_ed;
    logic [PW-1:0] ed_inc;
    logic [PW-1:0] ed_dec;
    logic [PW-1:0] rd_inc;
    logic          full;
    logic          full_after;
    logic          empty;
    logic          con_ok;
    logic [7:0]    key_char;
    logic [AW-1:0] base_addr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;

    // Indices of the active console.
    assign cur_rd     = r_rd_pos[r_active];
    assign cur_cm     = r_cm_pos[r_active];
    assign cur_ed     = r_ed_pos[r_active];
    assign ed_inc     = f_inc(cur_ed);
    assign ed_dec     = f_dec(cur_ed);
    assign rd_inc     = f_inc(cur_rd);
    assign full       = (cur_ed[SW-1:0] == cur_rd[SW-1:0]) && (cur_ed[SW] != cur_rd[SW]);
    assign full_after = (ed_inc[SW-1:0] == cur_rd[SW-1:0]) && (ed_inc[SW] != cur_rd[SW]);
    assign empty      = (cur_rd == cur_cm);
    assign con_ok     = (int'(r_item.console_index) < CONSOLE_COUNT)
                     && (int'(r_item.console_index) == int'(r_active));
    assign key_char   = (r_item.key == K_CR) ? K_LF : r_item.key;
    assign base_addr  = AW'(int'(r_active) * BUFFER_DEPTH);

    // Line store addresses.
    assign mem_waddr = base_addr + AW'(cur_ed[SW-1:0]);
    assign mem_raddr = i_cmd.kill_rd ? base_addr + AW'(ed_dec[SW-1:0])
                                     : base_addr + AW'(cur_rd[SW-1:0]);

    // Status toward the controller.
    assign o_sts.is_kill   = (r_item.action == ACT_KEY) && (r_item.key == K_CTRL_U);
    assign o_sts.read_go   = (r_item.action == ACT_READ) && con_ok && !empty;
    assign o_sts.kill_more = (cur_ed != cur_cm);
    assign o_sts.hit_lf    = (r_mem_q == K_LF);
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

    // Next values of indices and the result for each command.
    always_comb begin
        n_active   = r_active;
        n_rd       = cur_rd;
        n_cm       = cur_cm;
        n_ed       = cur_ed;
        n_out      = '0;
        w_out_load = 1'b0;
        mem_we     = 1'b0;

        if (i_cmd.exec) begin
            w_out_load = 1'b1;
            if (r_item.action == ACT_KEY) begin
                case (r_item.key)
                    K_CTRL_P: begin
                        n_out.dump_request = DUMP_PROC;
                    end
                    K_CTRL_Q: begin
                        n_out.dump_request = DUMP_PRIO;
                    end
                    K_CTRL_S: begin
                        n_active       = (int'(r_active) == CONSOLE_COUNT - 1)
                                       ? '0 : r_active + CW'(1);
                        n_out.switched = 1'b1;
                    end
                    K_CTRL_H, K_DEL: begin
                        if (cur_ed != cur_cm) begin
                            n_ed              = ed_dec;
                            n_out.echo_kind   = ECHO_ERASE;
                            n_out.erase_count = 8'd1;
                        end
                    end
                    default: begin
                        // Ordinary byte: store and echo unless zero or the ring is full.
                        if (r_item.key != 8'd0 && !full) begin
                            mem_we          = 1'b1;
                            n_ed            = ed_inc;
                            n_out.echo_kind = ECHO_BYTE;
                            n_out.echo_byte = key_char;
                            if (key_char == K_LF || key_char == K_CTRL_D || full_after) begin
                                n_cm                 = ed_inc;
                                n_out.line_committed = 1'b1;
                            end
                        end
                    end
                endcase
            end else begin
                // A read that cannot pop a byte.
                n_out.read_status = con_ok ? RS_EMPTY : RS_INACTIVE;
            end
        end else if (i_cmd.kill_step) begin
            n_ed = ed_dec;
        end else if (i_cmd.kill_done) begin
            w_out_load = 1'b1;
            if (r_cnt != '0) begin
                n_out.echo_kind   = ECHO_ERASE;
                n_out.erase_count = 8'(r_cnt);
            end
        end else if (i_cmd.rd_done) begin
            w_out_load = 1'b1;
            if (r_mem_q == K_CTRL_D) begin
                if (r_item.first_of_read) begin
                    n_rd              = rd_inc;
                    n_out.read_status = RS_EOF;
                end else begin
                    n_out.read_status = RS_EOF_HELD;
                end
            end else begin
                n_rd              = rd_inc;
                n_out.read_status = (r_mem_q == K_LF) ? RS_NEWLINE : RS_BYTE;
                n_out.read_byte   = r_mem_q;
            end
        end
        n_out.active_now = 2'(n_active);
    end

    // Control state: indices, active console and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CONSOLE_COUNT; c++) begin
                r_rd_pos[c] <= '0;
                r_cm_pos[c] <= '0;
                r_ed_pos[c] <= '0;
            end
            r_active  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_pos[r_active] <= n_rd;
            r_cm_pos[r_active] <= n_cm;
            r_ed_pos[r_active] <= n_ed;
            r_active           <= n_active;
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers: item, erase counter and result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_data;
        end
        if (i_cmd.kill_start) begin
            r_cnt <= '0;
        end else if (i_cmd.kill_step) begin
            r_cnt <= r_cnt + NW'(1);
        end
        if (w_out_load) begin
            r_out <= n_out;
        end
    end

    // Line store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= key_char;
        end
        if (i_cmd.kill_rd || i_cmd.rd_issue) begin
            r_mem_q <= r_mem[mem_raddr];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/multi_console_line_editor_core.sv -----
// Top level of the multi-console line editor: controller, datapath and checks.
//
//  Channel | Direction | Handshake                   | Payload
//  --------+-----------+-----------------------------+-------------------------
//  input   | in        | i_in_valid / o_in_ready     | i_in_data  (t_in)
//  output  | out       | o_out_valid / i_out_ready   | o_out_data (t_out)
//
// One item is worked at a time. A keystroke or a read that pops nothing has its
// result loaded from the dispatch state. A read that finds a committed byte first
// issues the registered line store read and loads its result from the read-wait
// state. Ctrl-U walks back one byte per step through the test and check states,
// stopping at a newline or the commit position; the kill walk reads the single line
// store port once per step, and the result is loaded from the finish state.
// Synchronous active-low reset clears all indices and the active console; the
// line store is not cleared. A stalled output holds the controller before its
// final step, while the pending result waits in the output register.
module multi_console_line_editor_core #(
    parameter int BUFFER_DEPTH  = 128,
    parameter int CONSOLE_COUNT = 3
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mcle_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output mcle_pkg::t_out o_out_data
);
    import mcle_pkg::*;

    t_cmd    w_cmd;
    t_status w_sts;

    mcle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    mcle_dp #(
        .BUFFER_DEPTH  (BUFFER_DEPTH),
        .CONSOLE_COUNT (CONSOLE_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // A result is only loaded when the output register is free.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.exec || w_cmd.kill_done || w_cmd.rd_done) |-> w_sts.out_free)
        else $error("result loaded over a pending output");

    // While a transfer can be taken, no item is being finished.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !(w_cmd.exec || w_cmd.kill_done || w_cmd.rd_done
                         || w_cmd.kill_step || w_cmd.rd_issue))
        else $error("item work while idle");

    // After a line store read is issued for a reader, the block stays busy.
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rd_issue |=> !o_in_ready)
        else $error("input taken before read completed");

    // A transfer in always raises the item load in the same cycle.
    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> w_cmd.load_item)
        else $error("transfer without item load");

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the multi-console line editor core.
module tb_top;

    import mcle_pkg::*;

    localparam int DEPTH          = 128;
    localparam int CONSOLES       = 3;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int MAX_REPORTS    = 10;

    // Clock, reset and block ports.
    logic i_clk      = 1'b0;
    logic i_rst_n    = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_data  = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    // Predicted editor state: ring bytes, positions and the active console.
    logic [7:0] ring_bytes [CONSOLES*DEPTH] = '{default: 8'h00};
    logic [7:0] rd_pos [CONSOLES] = '{default: 8'h00};
    logic [7:0] cm_pos [CONSOLES] = '{default: 8'h00};
    logic [7:0] ed_pos [CONSOLES] = '{default: 8'h00};
    logic [1:0] cur_console = 2'd0;

    // Results still owed by the block, oldest first.
    t_out expected_results [$];

    // Traffic shaping and bookkeeping.
    int tx_idle_pct   = 7;
    int rx_idle_pct   = 78;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int items_sent    = 0;
    int mismatches    = 0;
    int results_seen  = 0;
    int commits_seen  = 0;
    int erases_seen   = 0;
    int switches_seen = 0;
    int dumps_seen    = 0;
    int eof_seen      = 0;
    int held_seen     = 0;
    int inactive_seen = 0;
    int full_drops    = 0;

    multi_console_line_editor_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Free-running clock with a period of 4.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Ring slot of a position within one console's buffer.
    function automatic int ring_slot(input logic [1:0] con, input logic [7:0] pos);
        return int'(con) * DEPTH + int'(pos) % DEPTH;
    endfunction

    // Works out the result of one item and advances the predicted state.
    function automatic t_out line_edit_predict(input t_in it);
        t_out       r;
        logic [1:0] a;
        logic [1:0] con;
        logic [7:0] ch;
        logic [7:0] fill;
        int         erased;
        r = '0;
        a = cur_console;
        if (it.action == ACT_KEY) begin
            case (it.key)
                K_CTRL_P: r.dump_request = DUMP_PROC;
                K_CTRL_Q: r.dump_request = DUMP_PRIO;
                K_CTRL_U: begin
                    // Kill walks back over uncommitted bytes, stopping at a newline.
                    erased = 0;
                    while (ed_pos[a] != cm_pos[a] &&
                           ring_bytes[ring_slot(a, ed_pos[a] - 8'd1)] != K_LF) begin
                        ed_pos[a] = ed_pos[a] - 8'd1;
                        erased++;
                    end
                    if (erased != 0) begin
                        r.echo_kind   = ECHO_ERASE;
                        r.erase_count = 8'(erased);
                    end
                end
                K_CTRL_S: begin
                    cur_console = (int'(cur_console) == CONSOLES - 1) ? 2'd0
                                                                      : cur_console + 2'd1;
                    r.switched  = 1'b1;
                end
                K_CTRL_H, K_DEL: begin
                    if (ed_pos[a] != cm_pos[a]) begin
                        ed_pos[a]     = ed_pos[a] - 8'd1;
                        r.echo_kind   = ECHO_ERASE;
                        r.erase_count = 8'd1;
                    end
                end
                default: begin
                    // Ordinary byte: store and echo unless zero or the ring is full.
                    fill = ed_pos[a] - rd_pos[a];
                    if (it.key != 8'h00 && fill < DEPTH) begin
                        ch = (it.key == K_CR) ? K_LF : it.key;
                        r.echo_kind = ECHO_BYTE;
                        r.echo_byte = ch;
                        ring_bytes[ring_slot(a, ed_pos[a])] = ch;
                        ed_pos[a] = ed_pos[a] + 8'd1;
                        fill = ed_pos[a] - rd_pos[a];
                        if (ch == K_LF || ch == K_CTRL_D || fill == DEPTH) begin
                            cm_pos[a]        = ed_pos[a];
                            r.line_committed = 1'b1;
                        end
                    end
                end
            endcase
        end else begin
            // Reader pops at most one committed byte, and only from the active console.
            con = it.console_index;
            if (int'(con) >= CONSOLES || con != cur_console) begin
                r.read_status = RS_INACTIVE;
            end else if (rd_pos[con] == cm_pos[con]) begin
                r.read_status = RS_EMPTY;
            end else begin
                ch = ring_bytes[ring_slot(con, rd_pos[con])];
                if (ch == K_CTRL_D) begin
                    if (it.first_of_read) begin
                        rd_pos[con]   = rd_pos[con] + 8'd1;
                        r.read_status = RS_EOF;
                    end else begin
                        r.read_status = RS_EOF_HELD;
                    end
                end else begin
                    rd_pos[con]   = rd_pos[con] + 8'd1;
                    r.read_status = (ch == K_LF) ? RS_NEWLINE : RS_BYTE;
                    r.read_byte   = ch;
                end
            end
        end
        r.active_now = cur_console;
        return r;
    endfunction

    // Keystroke item; the fields it ignores get random values.
    function automatic t_in make_key(input logic [7:0] k);
        t_in it;
        it.action        = ACT_KEY;
        it.key           = k;
        it.console_index = 2'($urandom_range(3));
        it.first_of_read = 1'($urandom_range(1));
        return it;
    endfunction

    // Read item; the key it ignores gets a random value.
    function automatic t_in make_read(input logic [1:0] con, input logic fresh);
        t_in it;
        it.action        = ACT_READ;
        it.key           = 8'($urandom_range(255));
        it.console_index = con;
        it.first_of_read = fresh;
        return it;
    endfunction

    function automatic logic [7:0] printable_key();
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    function automatic string show_result(input t_out r);
        return $sformatf("kind=%0d echo=%h erase=%0d commit=%0d active=%0d sw=%0d dump=%0d rs=%0d rb=%h",
                         r.echo_kind, r.echo_byte, r.erase_count, r.line_committed,
                         r.active_now, r.switched, r.dump_request, r.read_status, r.read_byte);
    endfunction

    function automatic bit fields_match(input t_out e, input t_out g);
        return e.echo_kind === g.echo_kind && e.echo_byte === g.echo_byte &&
               e.erase_count === g.erase_count && e.line_committed === g.line_committed &&
               e.active_now === g.active_now && e.switched === g.switched &&
               e.dump_request === g.dump_request && e.read_status === g.read_status &&
               e.read_byte === g.read_byte;
    endfunction

    // Offers one item, waits for its transfer and records the expected result.
    task automatic send_item(input t_in it, output t_out exp);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        exp = line_edit_predict(it);
        expected_results.push_back(exp);
        if (!(it.action == ACT_KEY && it.key == 8'h00)) items_sent++;
    endtask

    task automatic send_key(input logic [7:0] k);
        t_out r;
        send_item(make_key(k), r);
        if (k != 8'h00 && k != K_CTRL_H && k != K_DEL && k != K_CTRL_U && k != K_CTRL_S &&
            k != K_CTRL_P && k != K_CTRL_Q && r.echo_kind == ECHO_NONE)
            full_drops++;
    endtask

    // Reads the active console until it is empty, as a reader would.
    task automatic read_pending();
        t_out r;
        logic fresh;
        fresh = 1'b1;
        while (rd_pos[cur_console] != cm_pos[cur_console]) begin
            send_item(make_read(cur_console, fresh), r);
            fresh = (r.read_status != RS_BYTE);
        end
    endtask

    // Sender stops offering until every owed result has come back.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    // One typed line with edits, a terminator and usually a read of it.
    task automatic send_line();
        int len;
        int pick;
        len = ($urandom_range(19) == 0) ? $urandom_range(60, 140) : $urandom_range(1, 20);
        repeat (len) begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_key(pick < 4 ? K_CTRL_H : K_DEL);
            else if (pick < 10)
                send_key(K_CTRL_U);
            else if (pick < 20)
                send_key(8'($urandom_range(8'h80, 8'hFF)));
            else
                send_key(printable_key());
        end
        pick = $urandom_range(9);
        send_key(pick < 4 ? K_CR : (pick < 8 ? K_LF : K_CTRL_D));
        if ($urandom_range(4) != 0) read_pending();
    endtask

    // Any single item: stray reads, control keys and raw bytes.
    function automatic t_in noise_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30)
            return make_read(($urandom_range(9) < 7) ? cur_console : 2'($urandom_range(3)),
                             1'($urandom_range(1)));
        else if (pick < 45)
            return make_key(8'($urandom_range(255)));
        else if (pick < 55)
            return make_key(K_CTRL_S);
        else if (pick < 62)
            return make_key(($urandom_range(1) == 0) ? K_CTRL_P : K_CTRL_Q);
        else if (pick < 72)
            return make_key(($urandom_range(1) == 0) ? K_CTRL_H : K_DEL);
        else if (pick < 77)
            return make_key(K_CTRL_U);
        else if (pick < 85)
            return make_key(K_CTRL_D);
        else
            return make_key(($urandom_range(3) == 0) ? K_CR : printable_key());
    endfunction

    // Every kind of operation and its edge cases, in a fixed order.
    task automatic test_directed_edits();
        t_in  seq [$];
        t_out r;
        seq.push_back(make_key(8'h00));
        seq.push_back(make_key(K_CTRL_H));
        seq.push_back(make_key(K_CTRL_U));
        seq.push_back(make_read(2'd0, 1'b1));
        seq.push_back(make_key(8'h41));
        seq.push_back(make_key(8'hFF));
        seq.push_back(make_key(8'h80));
        seq.push_back(make_key(8'h01));
        seq.push_back(make_key(K_DEL));
        seq.push_back(make_key(K_CR));
        seq.push_back(make_read(2'd3, 1'b1));
        seq.push_back(make_read(2'd1, 1'b1));
        seq.push_back(make_read(2'd0, 1'b1));
        seq.push_back(make_read(2'd0, 1'b0));
        seq.push_back(make_read(2'd0, 1'b0));
        seq.push_back(make_read(2'd0, 1'b0));
        seq.push_back(make_key(8'h7A));
        seq.push_back(make_key(K_CTRL_D));
        seq.push_back(make_read(2'd0, 1'b1));
        seq.push_back(make_read(2'd0, 1'b0));
        seq.push_back(make_read(2'd0, 1'b1));
        seq.push_back(make_key(K_CTRL_P));
        seq.push_back(make_key(K_CTRL_Q));
        seq.push_back(make_key(K_CTRL_S));
        seq.push_back(make_read(2'd0, 1'b1));
        seq.push_back(make_key(K_CTRL_S));
        seq.push_back(make_key(K_CTRL_S));
        foreach (seq[i]) send_item(seq[i], r);
    endtask

    // Fill one ring to the brim, overflow it, then empty it.
    task automatic test_full_ring();
        t_out r;
        send_key(K_LF);
        read_pending();
        repeat (DEPTH) send_key(printable_key());
        send_key(8'h61);
        send_key(K_CTRL_H);
        send_key(K_CTRL_U);
        send_key(K_CR);
        read_pending();
        send_item(make_read(cur_console, 1'b1), r);
    endtask

    // Longest possible kill, then a kill with nothing left.
    task automatic test_long_kill();
        send_key(K_LF);
        read_pending();
        repeat (DEPTH - 1) send_key(printable_key());
        send_key(K_CTRL_U);
        send_key(K_CTRL_U);
        repeat (40) send_key(printable_key());
        send_key(K_CTRL_H);
        send_key(K_CTRL_D);
        read_pending();
    endtask

    // Receiver holds off while the sender keeps offering, then the sender drains.
    task automatic test_output_stall();
        hold_requests++;
        repeat (12) send_key(printable_key());
        send_key(K_LF);
        wait_for_results();
    endtask

    // Mostly well-formed lines with random content, the rest single random items.
    task automatic test_random_traffic(input int n);
        t_out r;
        int   stop_at;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 65)
                send_line();
            else
                send_item(noise_item(), r);
        end
    endtask

    // Compares one result transfer with the oldest expectation.
    task automatic check_result(input t_out got);
        t_out exp;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("Unexpected result with nothing pending: %s", show_result(got));
        end else begin
            exp = expected_results.pop_front();
            results_seen++;
            if (!fields_match(exp, got)) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("Result %0d mismatch", results_seen);
                    $display("  expected %s", show_result(exp));
                    $display("  actual   %s", show_result(got));
                end
            end
            if (exp.line_committed) commits_seen++;
            if (exp.echo_kind == ECHO_ERASE) erases_seen++;
            if (exp.switched) switches_seen++;
            if (exp.dump_request != DUMP_NONE) dumps_seen++;
            if (exp.read_status == RS_EOF) eof_seen++;
            if (exp.read_status == RS_EOF_HELD) held_seen++;
            if (exp.read_status == RS_INACTIVE) inactive_seen++;
        end
    endtask

    // Result checker: one check per output transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) check_result(o_out_data);
    end

    // Receiver: random ready, with long hold-offs on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = RX_HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Count cycles with no transfer on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    // Watchdog on a stuck block.
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Test sequence.
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edits();
        test_full_ring();
        test_long_kill();
        test_random_traffic(160);
        test_output_stall();

        tx_idle_pct = 78;
        rx_idle_pct = 7;
        test_random_traffic(160);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(160);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $display("%0d expected results never arrived", expected_results.size());
            mismatches += expected_results.size();
        end

        $display("Covered %0d items, %0d results, %0d commits, %0d erases, %0d drops on full.",
                 items_sent, results_seen, commits_seen, erases_seen, full_drops);
        $display("Console switches %0d, dumps %0d, eof %0d, eof held %0d, inactive reads %0d.",
                 switches_seen, dumps_seen, eof_seen, held_seen, inactive_seen);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("Failures: %0d", mismatches);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
